>>> rtl/core/pal_pkg.sv
package pal_pkg;

  // list geometry
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // field widths
  localparam int MODE_W   = 3;
  localparam int POS_W    = 5;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int FOUND_W  = 4;
  localparam int COUNT_W  = 5;

  // compare width for position / count / cursor arithmetic
  localparam int CMP_W    = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  // request codes
  localparam logic [MODE_W-1:0] MD_INSERT = 3'd0;
  localparam logic [MODE_W-1:0] MD_REMOVE = 3'd1;
  localparam logic [MODE_W-1:0] MD_SEARCH = 3'd2;
  localparam logic [MODE_W-1:0] MD_READ   = 3'd3;
  localparam logic [MODE_W-1:0] MD_CLEAR  = 3'd4;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CUR_HOLD = 3'd0,
    CUR_CNT  = 3'd1,
    CUR_POS  = 3'd2,
    CUR_ZERO = 3'd3,
    CUR_INC  = 3'd4,
    CUR_DEC  = 3'd5
  } cur_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2,
    CNT_CLR  = 2'd3
  } cnt_op_t;

  // read address relative to the next cursor value
  typedef enum logic [1:0] {
    RD_CUR  = 2'd0,
    RD_PREV = 2'd1,
    RD_NEXT = 2'd2
  } rd_sel_t;

  typedef struct packed {
    logic    capture;
    cur_op_t cur_op;
    cnt_op_t cnt_op;
    rd_sel_t rd_sel;
    logic    mem_we;
    logic    wr_val;
    logic    set_st;
    status_t st;
    logic    set_found;
    logic    set_data;
    logic    push;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              pos_gt_cnt;
    logic              pos_eq_cnt;
    logic              pos_last;
    logic              cnt_full;
    logic              cnt_zero;
    logic              up_last;
    logic              dn_last;
    logic              scan_last;
    logic              match;
    logic              out_free;
  } flags_t;

endpackage

>>> rtl/core/pal_if.sv
interface pal_in_if import pal_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] item_value;

  modport source (output valid, mode, position, item_value, input ready);
  modport sink   (input valid, mode, position, item_value, output ready);
endinterface

interface pal_out_if import pal_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [FOUND_W-1:0]       found_position;
  logic signed [DATA_W-1:0] read_data;
  logic [COUNT_W-1:0]       count_after;

  modport source (output valid, status, found_position, read_data, count_after, input ready);
  modport sink   (input valid, status, found_position, read_data, count_after, output ready);
endinterface

>>> rtl/core/positional_array_list.sv
// Steps: insert shifts the entries from the position on up by one, then writes
//   the item; remove shifts the later entries down (a last entry only lowers the
//   count); search scans from entry 0 to a match or the list end; read fetches
//   the entry; clear and a range, full or unused-mode request end at decode. The
//   shift moves one entry per cycle; a new request waits until the result is pushed.
// Reset: synchronous, active low; clears the entry count and the handshakes.
//   Entry storage is not cleared and needs no clearing pass.
module positional_array_list import pal_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  pal_in_if.sink    in_ch,
  pal_out_if.source out_ch
);

  cmd_t   cmd;
  flags_t flags;
  logic   in_ready;

  // sequencer: one request at a time; a finished result sits in the output
  // register while the next request is taken and worked on
  pal_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .flags    (flags),
    .cmd      (cmd)
  );

  // entry memory (one write, one registered read per cycle), count, cursor,
  // pending result and output register
  pal_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mode       (in_ch.mode),
    .in_position   (in_ch.position),
    .in_item_value (in_ch.item_value),
    .cmd           (cmd),
    .flags         (flags),
    .out_ch        (out_ch)
  );

  assign in_ch.ready = in_ready;

endmodule

>>> rtl/core/pal_ctrl.sv
module pal_ctrl import pal_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  flags_t flags,
  output cmd_t   cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECODE = 8'b0000_0010,
    S_UP     = 8'b0000_0100,
    S_PUT    = 8'b0000_1000,
    S_DN     = 8'b0001_0000,
    S_SCAN   = 8'b0010_0000,
    S_RDW    = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.cur_op = CUR_HOLD;
    cmd.cnt_op = CNT_HOLD;
    cmd.rd_sel = RD_CUR;
    cmd.st     = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_DONE;
        case (flags.mode)
          MD_INSERT: begin
            if (flags.pos_gt_cnt) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_RANGE;
            end else if (flags.cnt_full) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_FULL;
            end else begin
              cmd.cur_op = CUR_CNT;
              cmd.rd_sel = RD_PREV;
              state_nxt  = flags.pos_eq_cnt ? S_PUT : S_UP;
            end
          end
          MD_REMOVE: begin
            if (flags.pos_gt_cnt || flags.pos_eq_cnt) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_RANGE;
            end else if (flags.pos_last) begin
              cmd.cnt_op = CNT_DEC;
            end else begin
              cmd.cur_op = CUR_POS;
              cmd.rd_sel = RD_NEXT;
              state_nxt  = S_DN;
            end
          end
          MD_SEARCH: begin
            if (flags.cnt_zero) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_NOTFOUND;
            end else begin
              cmd.cur_op = CUR_ZERO;
              cmd.rd_sel = RD_CUR;
              state_nxt  = S_SCAN;
            end
          end
          MD_READ: begin
            if (flags.pos_gt_cnt || flags.pos_eq_cnt) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_RANGE;
            end else begin
              cmd.cur_op = CUR_POS;
              cmd.rd_sel = RD_CUR;
              state_nxt  = S_RDW;
            end
          end
          MD_CLEAR: begin
            cmd.cnt_op = CNT_CLR;
          end
          default: begin
          end
        endcase
      end
      S_UP: begin
        cmd.mem_we = 1'b1;
        cmd.cur_op = CUR_DEC;
        cmd.rd_sel = RD_PREV;
        if (flags.up_last) begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        cmd.mem_we = 1'b1;
        cmd.wr_val = 1'b1;
        cmd.cnt_op = CNT_INC;
        state_nxt  = S_DONE;
      end
      S_DN: begin
        cmd.mem_we = 1'b1;
        cmd.cur_op = CUR_INC;
        cmd.rd_sel = RD_NEXT;
        if (flags.dn_last) begin
          cmd.cnt_op = CNT_DEC;
          state_nxt  = S_DONE;
        end
      end
      S_SCAN: begin
        if (flags.match) begin
          cmd.set_found = 1'b1;
          state_nxt     = S_DONE;
        end else if (flags.scan_last) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_NOTFOUND;
          state_nxt  = S_DONE;
        end else begin
          cmd.cur_op = CUR_INC;
          cmd.rd_sel = RD_CUR;
        end
      end
      S_RDW: begin
        cmd.set_data = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (flags.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/pal_dp.sv
module pal_dp import pal_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [MODE_W-1:0]        in_mode,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_item_value,
  input  cmd_t                     cmd,
  output flags_t                   flags,
  pal_out_if.source                out_ch
);

  // request
  logic [MODE_W-1:0] mode_r;
  logic [POS_W-1:0]  pos_r;
  logic [DATA_W-1:0] val_r;

  // list state
  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rdata_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  cur_r, cur_nxt;
  logic [CNT_W-1:0]  rd_full;
  logic [IDX_W-1:0]  rd_addr;
  logic [DATA_W-1:0] wdata;

  // pending result
  status_t           st_r;
  logic [FOUND_W-1:0] found_r;
  logic [DATA_W-1:0] data_r;

  // output register
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [FOUND_W-1:0]  out_found_r;
  logic [DATA_W-1:0]   out_data_r;
  logic [COUNT_W-1:0]  out_count_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      pos_r  <= in_position;
      val_r  <= in_item_value;
    end
  end

  always_comb begin
    case (cmd.cur_op)
      CUR_CNT:  cur_nxt = cnt_r;
      CUR_POS:  cur_nxt = CNT_W'(pos_r);
      CUR_ZERO: cur_nxt = '0;
      CUR_INC:  cur_nxt = cur_r + CNT_W'(1);
      CUR_DEC:  cur_nxt = cur_r - CNT_W'(1);
      default:  cur_nxt = cur_r;
    endcase
  end

  always_comb begin
    case (cmd.cnt_op)
      CNT_INC: cnt_nxt = cnt_r + CNT_W'(1);
      CNT_DEC: cnt_nxt = cnt_r - CNT_W'(1);
      CNT_CLR: cnt_nxt = '0;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  // read address follows the cursor value of the next cycle
  always_comb begin
    case (cmd.rd_sel)
      RD_PREV: rd_full = cur_nxt - CNT_W'(1);
      RD_NEXT: rd_full = cur_nxt + CNT_W'(1);
      default: rd_full = cur_nxt;
    endcase
  end

  assign rd_addr = rd_full[IDX_W-1:0];
  assign wdata   = cmd.wr_val ? val_r : rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[cur_r[IDX_W-1:0]] <= wdata;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      st_r    <= ST_OK;
      found_r <= '0;
      data_r  <= '0;
    end else begin
      if (cmd.set_st) begin
        st_r <= cmd.st;
      end
      if (cmd.set_found) begin
        found_r <= FOUND_W'(cur_r);
      end
      if (cmd.set_data) begin
        data_r <= rdata_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_status_r <= st_r;
      out_found_r  <= found_r;
      out_data_r   <= data_r;
      out_count_r  <= COUNT_W'(cnt_r);
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.found_position = out_found_r;
  assign out_ch.read_data      = out_data_r;
  assign out_ch.count_after    = out_count_r;

  always_comb begin
    flags.mode       = mode_r;
    flags.pos_gt_cnt = CMP_W'(pos_r) > CMP_W'(cnt_r);
    flags.pos_eq_cnt = CMP_W'(pos_r) == CMP_W'(cnt_r);
    flags.pos_last   = (CMP_W'(pos_r) + CMP_W'(1)) == CMP_W'(cnt_r);
    flags.cnt_full   = CMP_W'(cnt_r) == CMP_W'(CAPACITY);
    flags.cnt_zero   = (cnt_r == '0);
    flags.up_last    = CMP_W'(cur_r) == (CMP_W'(pos_r) + CMP_W'(1));
    flags.dn_last    = (CMP_W'(cur_r) + CMP_W'(2)) == CMP_W'(cnt_r);
    flags.scan_last  = (CMP_W'(cur_r) + CMP_W'(1)) == CMP_W'(cnt_r);
    flags.match      = (rdata_r == val_r);
    flags.out_free   = !out_valid_r || out_ch.ready;
  end

endmodule
